@@ design/ntp_seconds_to_local_calendar_core_defines.svh @@
// Assertion macros shared by the calendar core modules.
// No dependencies; included by every module that carries assertions.
`ifndef NTP_SECONDS_TO_LOCAL_CALENDAR_CORE_DEFINES_SVH
`define NTP_SECONDS_TO_LOCAL_CALENDAR_CORE_DEFINES_SVH

// same-cycle implication, off while reset is low
`define NTPCAL_ASSERT_IMPL(name, clk_i, rstn_i, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is low
`define NTPCAL_ASSERT_NEXT(name, clk_i, rstn_i, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/ntpcal_pkg.sv @@
// Shared types, constants and reciprocal multipliers for the calendar core.
// No dependencies; imported by every module of the core.
`default_nettype none

package ntpcal_pkg;

  typedef struct packed {
    logic [7:0] year;
    logic [3:0] month;
    logic [4:0] mday;
    logic [2:0] wday;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } cal_t;

  localparam logic [31:0] NTP_UNIX_OFFSET = 32'd2208988800;
  localparam logic [17:0] SECS_PER_HOUR   = 18'd3600;
  localparam logic [17:0] SECS_PER_DAY    = 18'd86400;
  localparam logic [5:0]  LAST_WEEK_DAY   = 6'd25;

  localparam logic [4:0]  ZONE_RESET      = 5'd1;
  localparam logic [17:0] BIAS_RESET      = 18'(32'd3600 + 32'd86400);

  localparam logic [19:0] DAY_SHIFT       = 20'd719467;
  localparam logic [19:0] ERA4_BASE       = 20'(4 * 146097);
  localparam logic [19:0] ERA5_BASE       = 20'(5 * 146097);
  localparam logic [17:0] DAYS_PER_ERA_M1 = 18'd146096;
  localparam logic [17:0] CENT_DAYS       = 18'd36524;

  localparam logic [3:0] MON_MAR = 4'd2;
  localparam logic [3:0] MON_APR = 4'd3;
  localparam logic [3:0] MON_SEP = 4'd8;
  localparam logic [3:0] MON_OCT = 4'd9;

  // q = (x * RCP) >> K is exact for x below 2^N, with K = N + ceil(log2 d)
  localparam int K_675  = 36;
  localparam int K_7    = 19;
  localparam int K_3600 = 29;
  localparam int K_60   = 18;
  localparam int K_1460 = 29;
  localparam int K_365  = 27;
  localparam int K_100  = 16;
  localparam int K_153  = 19;

  localparam logic [26:0] RCP_675  = 27'(((64'd1 << K_675)  + 64'd674)  / 64'd675);
  localparam logic [16:0] RCP_7    = 17'(((64'd1 << K_7)    + 64'd6)    / 64'd7);
  localparam logic [17:0] RCP_3600 = 18'(((64'd1 << K_3600) + 64'd3599) / 64'd3600);
  localparam logic [12:0] RCP_60   = 13'(((64'd1 << K_60)   + 64'd59)   / 64'd60);
  localparam logic [18:0] RCP_1460 = 19'(((64'd1 << K_1460) + 64'd1459) / 64'd1460);
  localparam logic [18:0] RCP_365  = 19'(((64'd1 << K_365)  + 64'd364)  / 64'd365);
  localparam logic [9:0]  RCP_100  = 10'(((64'd1 << K_100)  + 64'd99)   / 64'd100);
  localparam logic [11:0] RCP_153  = 12'(((64'd1 << K_153)  + 64'd152)  / 64'd153);

  // day of year (from March 1) at which month index mp starts
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    unique case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/ntpcal_split.sv @@
// Ten-stage pipeline that splits a biased second count into date and time.
// Depends on ntpcal_pkg and the core assertion macros.
`default_nettype none
`include "ntp_seconds_to_local_calendar_core_defines.svh"

module ntpcal_split (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [32:0]       in_secs,
  output logic              out_valid,
  output ntpcal_pkg::cal_t  out_cal
);
  import ntpcal_pkg::*;

  // stage 1: day count from seconds
  logic [52:0] p1;
  logic        s1_v_r;
  logic [15:0] s1_q_r;
  logic [25:0] s1_x_r;
  logic [6:0]  s1_lo_r;

  // stage 2: second of day, shifted day number
  logic [25:0] s2_rem;
  logic        s2_v_r;
  logic [16:0] s2_sod_r;
  logic [19:0] s2_z_r;
  logic [15:0] s2_w_r;

  // stage 3: day of era, hour, weekday quotient
  logic        s3_era5;
  logic [19:0] s3_doe;
  logic [34:0] p3h;
  logic [32:0] p3w;
  logic        s3_v_r;
  logic [17:0] s3_doe_r;
  logic        s3_era5_r;
  logic [16:0] s3_sod_r;
  logic [4:0]  s3_hour_r;
  logic [15:0] s3_w_r;
  logic [12:0] s3_wq_r;

  // stage 4: year-of-era corrections, rest of hour, weekday
  logic [36:0] p4c;
  logic [16:0] s4_rem;
  logic [15:0] s4_wd;
  logic        s4_v_r;
  logic [17:0] s4_doe_r;
  logic        s4_era5_r;
  logic [6:0]  s4_c1460_r;
  logic [2:0]  s4_c36524_r;
  logic        s4_cera_r;
  logic [4:0]  s4_hour_r;
  logic [11:0] s4_rem_r;
  logic [2:0]  s4_wday_r;

  // stage 5
  logic [24:0] p5m;
  logic        s5_v_r;
  logic [17:0] s5_yin_r;
  logic [17:0] s5_doe_r;
  logic        s5_era5_r;
  logic [4:0]  s5_hour_r;
  logic [11:0] s5_rem_r;
  logic [5:0]  s5_min_r;
  logic [2:0]  s5_wday_r;

  // stage 6
  logic [36:0] p6y;
  logic [11:0] s6_sec;
  logic        s6_v_r;
  logic [8:0]  s6_yoe_r;
  logic [17:0] s6_doe_r;
  logic        s6_era5_r;
  logic [4:0]  s6_hour_r;
  logic [5:0]  s6_min_r;
  logic [5:0]  s6_sec_r;
  logic [2:0]  s6_wday_r;

  // stage 7
  logic [18:0] p7c;
  logic        s7_v_r;
  logic [17:0] s7_t365_r;
  logic [1:0]  s7_y100_r;
  logic [8:0]  s7_yoe_r;
  logic [17:0] s7_doe_r;
  logic        s7_era5_r;
  logic [4:0]  s7_hour_r;
  logic [5:0]  s7_min_r;
  logic [5:0]  s7_sec_r;
  logic [2:0]  s7_wday_r;

  // stage 8
  logic [17:0] s8_doy;
  logic        s8_v_r;
  logic [8:0]  s8_doy_r;
  logic [8:0]  s8_yoe_r;
  logic        s8_era5_r;
  logic [4:0]  s8_hour_r;
  logic [5:0]  s8_min_r;
  logic [5:0]  s8_sec_r;
  logic [2:0]  s8_wday_r;

  // stage 9
  logic [10:0] s9_x;
  logic [22:0] p9m;
  logic        s9_v_r;
  logic [3:0]  s9_mp_r;
  logic [8:0]  s9_doy_r;
  logic [8:0]  s9_yoe_r;
  logic        s9_era5_r;
  logic [4:0]  s9_hour_r;
  logic [5:0]  s9_min_r;
  logic [5:0]  s9_sec_r;
  logic [2:0]  s9_wday_r;

  // stage 10
  logic [8:0]  s10_mday;
  logic [10:0] s10_year;
  logic        s10_jan;
  logic        s10_v_r;
  cal_t        s10_cal_r;
  cal_t        s10_cal_nxt;

  assign p1 = 53'(in_secs[32:7]) * 53'(RCP_675);

  assign s2_rem = s1_x_r - 26'(s1_q_r) * 26'd675;

  assign s3_era5 = (s2_z_r >= ERA5_BASE);
  assign s3_doe  = s2_z_r - (s3_era5 ? ERA5_BASE : ERA4_BASE);
  assign p3h     = 35'(s2_sod_r) * 35'(RCP_3600);
  assign p3w     = 33'(s2_w_r) * 33'(RCP_7);

  assign p4c    = 37'(s3_doe_r) * 37'(RCP_1460);
  assign s4_rem = s3_sod_r - 17'(s3_hour_r) * 17'd3600;
  assign s4_wd  = s3_w_r - 16'(s3_wq_r) * 16'd7;

  assign p5m = 25'(s4_rem_r) * 25'(RCP_60);

  assign p6y    = 37'(s5_yin_r) * 37'(RCP_365);
  assign s6_sec = s5_rem_r - 12'(s5_min_r) * 12'd60;

  assign p7c = 19'(s6_yoe_r) * 19'(RCP_100);

  assign s8_doy = s7_doe_r - s7_t365_r + 18'(s7_y100_r);

  assign s9_x = {s8_doy_r, 2'b00} + 11'(s8_doy_r) + 11'd2;
  assign p9m  = 23'(s9_x) * 23'(RCP_153);

  assign s10_mday = s9_doy_r - month_start(s9_mp_r) + 9'd1;
  assign s10_jan  = (s9_mp_r >= 4'd10);
  assign s10_year = 11'(s9_yoe_r) + (s9_era5_r ? 11'd400 : 11'd0) + 11'(s10_jan) - 11'd300;

  always_comb begin
    s10_cal_nxt.year   = s10_year[7:0];
    s10_cal_nxt.month  = s10_jan ? (s9_mp_r - 4'd10) : (s9_mp_r + 4'd2);
    s10_cal_nxt.mday   = s10_mday[4:0];
    s10_cal_nxt.wday   = s9_wday_r;
    s10_cal_nxt.hour   = s9_hour_r;
    s10_cal_nxt.minute = s9_min_r;
    s10_cal_nxt.second = s9_sec_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      s5_v_r  <= 1'b0;
      s6_v_r  <= 1'b0;
      s7_v_r  <= 1'b0;
      s8_v_r  <= 1'b0;
      s9_v_r  <= 1'b0;
      s10_v_r <= 1'b0;
    end else begin
      s1_v_r  <= in_valid;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r;
      s5_v_r  <= s4_v_r;
      s6_v_r  <= s5_v_r;
      s7_v_r  <= s6_v_r;
      s8_v_r  <= s7_v_r;
      s9_v_r  <= s8_v_r;
      s10_v_r <= s9_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_q_r  <= p1[K_675 +: 16];
    s1_x_r  <= in_secs[32:7];
    s1_lo_r <= in_secs[6:0];

    s2_sod_r <= {s2_rem[9:0], s1_lo_r};
    s2_z_r   <= 20'(s1_q_r) + DAY_SHIFT;
    s2_w_r   <= s1_q_r + 16'd3;

    s3_doe_r  <= s3_doe[17:0];
    s3_era5_r <= s3_era5;
    s3_sod_r  <= s2_sod_r;
    s3_hour_r <= p3h[K_3600 +: 5];
    s3_w_r    <= s2_w_r;
    s3_wq_r   <= p3w[K_7 +: 13];

    s4_doe_r    <= s3_doe_r;
    s4_era5_r   <= s3_era5_r;
    s4_c1460_r  <= p4c[K_1460 +: 7];
    s4_c36524_r <= 3'(s3_doe_r >= CENT_DAYS) + 3'(s3_doe_r >= 18'(2 * 36524))
                 + 3'(s3_doe_r >= 18'(3 * 36524)) + 3'(s3_doe_r >= 18'(4 * 36524));
    s4_cera_r   <= (s3_doe_r == DAYS_PER_ERA_M1);
    s4_hour_r   <= s3_hour_r;
    s4_rem_r    <= s4_rem[11:0];
    s4_wday_r   <= s4_wd[2:0];

    s5_yin_r  <= s4_doe_r - 18'(s4_c1460_r) + 18'(s4_c36524_r) - 18'(s4_cera_r);
    s5_doe_r  <= s4_doe_r;
    s5_era5_r <= s4_era5_r;
    s5_hour_r <= s4_hour_r;
    s5_rem_r  <= s4_rem_r;
    s5_min_r  <= p5m[K_60 +: 6];
    s5_wday_r <= s4_wday_r;

    s6_yoe_r  <= p6y[K_365 +: 9];
    s6_doe_r  <= s5_doe_r;
    s6_era5_r <= s5_era5_r;
    s6_hour_r <= s5_hour_r;
    s6_min_r  <= s5_min_r;
    s6_sec_r  <= s6_sec[5:0];
    s6_wday_r <= s5_wday_r;

    s7_t365_r <= 18'(s6_yoe_r) * 18'd365 + 18'(s6_yoe_r[8:2]);
    s7_y100_r <= p7c[K_100 +: 2];
    s7_yoe_r  <= s6_yoe_r;
    s7_doe_r  <= s6_doe_r;
    s7_era5_r <= s6_era5_r;
    s7_hour_r <= s6_hour_r;
    s7_min_r  <= s6_min_r;
    s7_sec_r  <= s6_sec_r;
    s7_wday_r <= s6_wday_r;

    s8_doy_r  <= s8_doy[8:0];
    s8_yoe_r  <= s7_yoe_r;
    s8_era5_r <= s7_era5_r;
    s8_hour_r <= s7_hour_r;
    s8_min_r  <= s7_min_r;
    s8_sec_r  <= s7_sec_r;
    s8_wday_r <= s7_wday_r;

    s9_mp_r   <= p9m[K_153 +: 4];
    s9_doy_r  <= s8_doy_r;
    s9_yoe_r  <= s8_yoe_r;
    s9_era5_r <= s8_era5_r;
    s9_hour_r <= s8_hour_r;
    s9_min_r  <= s8_min_r;
    s9_sec_r  <= s8_sec_r;
    s9_wday_r <= s8_wday_r;

    s10_cal_r <= s10_cal_nxt;
  end

  assign out_valid = s10_v_r;
  assign out_cal   = s10_cal_r;

  `NTPCAL_ASSERT_IMPL(a_sod_range, clk, rst_n, s2_v_r, s2_sod_r < 17'(SECS_PER_DAY), "sod out of range")
  `NTPCAL_ASSERT_IMPL(a_doe_range, clk, rst_n, s3_v_r, s3_doe_r <= DAYS_PER_ERA_M1, "doe out of range")
  `NTPCAL_ASSERT_IMPL(a_cal_range, clk, rst_n, s10_v_r, (s10_cal_r.mday >= 5'd1) && (s10_cal_r.month <= 4'd11) && (s10_cal_r.hour <= 5'd23) && (s10_cal_r.minute <= 6'd59) && (s10_cal_r.second <= 6'd59) && (s10_cal_r.wday <= 3'd6), "calendar field out of range")

endmodule

`default_nettype wire

@@ design/ntpcal_dst.sv @@
// Summer-time decision on standard local time and final output register.
// Depends on ntpcal_pkg and the core assertion macros.
`default_nettype none
`include "ntp_seconds_to_local_calendar_core_defines.svh"

module ntpcal_dst (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  ntpcal_pkg::cal_t  in_std,
  input  ntpcal_pkg::cal_t  in_sum,
  output logic              out_strobe,
  output ntpcal_pkg::cal_t  out_cal,
  output logic              out_summer
);
  import ntpcal_pkg::*;

  logic late;
  logic summer_nxt;
  logic strobe_r;
  cal_t cal_r;
  logic summer_r;

  assign late = ({1'b0, in_std.mday} >= (6'(in_std.wday) + LAST_WEEK_DAY));

  always_comb begin
    priority if ((in_std.month >= MON_APR) && (in_std.month <= MON_SEP)) begin
      summer_nxt = 1'b1;
    end else if (in_std.month == MON_MAR) begin
      summer_nxt = late && ((in_std.wday != 3'd0) || (in_std.hour >= 5'd2));
    end else if (in_std.month == MON_OCT) begin
      summer_nxt = !late || ((in_std.wday == 3'd0) && (in_std.hour < 5'd3));
    end else begin
      summer_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= in_valid;
    end
    cal_r    <= summer_nxt ? in_sum : in_std;
    summer_r <= summer_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_cal    = cal_r;
  assign out_summer = summer_r;

  `NTPCAL_ASSERT_IMPL(a_summer_month, clk, rst_n, strobe_r && summer_r, (cal_r.month >= MON_MAR) && (cal_r.month <= MON_OCT), "summer time outside March to October")
  `NTPCAL_ASSERT_IMPL(a_std_month, clk, rst_n, strobe_r && !summer_r, (cal_r.month < MON_APR) || (cal_r.month > MON_SEP), "standard time in summer months")
  `NTPCAL_ASSERT_IMPL(a_march_late, clk, rst_n, strobe_r && summer_r && (cal_r.month == MON_MAR), cal_r.mday >= 5'd25, "early March summer time")

endmodule

`default_nettype wire

@@ design/ntp_seconds_to_local_calendar_core.sv @@
// Top level: NTP seconds to local calendar with European summer time.
// Depends on ntpcal_pkg, ntpcal_split, ntpcal_dst and the assertion macros.
//
//   channel   ports                                   handshake
//   request   start, busy, in_ntp_seconds             start & !busy
//   result    out_strobe, out_* fields                out_strobe, one cycle
//   config    cfg_valid, cfg_ready, cfg_zone_*        cfg_valid & cfg_ready
//
// One request per cycle while busy is low; each result passes through an input
// stage, ten split stages and a summer-time select stage.
// Two split pipelines run side by side: standard time and standard plus one hour.
// busy is high during reset and is cleared by the clock once reset is released; it is not raised otherwise.
// Reset sets the zone offset to +1 hour and drops all requests in flight.
// The receiver cannot stall; results are never held.
`default_nettype none
`include "ntp_seconds_to_local_calendar_core_defines.svh"

module ntp_seconds_to_local_calendar_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [31:0]       in_ntp_seconds,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic signed [4:0] cfg_zone_offset_hours,
  output logic              out_strobe,
  output logic [7:0]        out_year_since_1900,
  output logic [3:0]        out_month,
  output logic [4:0]        out_day_of_month,
  output logic [2:0]        out_weekday,
  output logic [4:0]        out_hour,
  output logic [5:0]        out_minute,
  output logic [5:0]        out_second,
  output logic              out_summer_time
);
  import ntpcal_pkg::*;

  logic               busy_r;
  logic               accept;
  logic signed [18:0] bias_s;
  logic [17:0]        bias_a_r;
  logic [17:0]        bias_b_r;
  logic [31:0]        unix;
  logic               v0_r;
  logic [32:0]        ua_r;
  logic [32:0]        ub_r;
  logic               v_a_w;
  logic               v_b_w;
  cal_t               cal_a_w;
  cal_t               cal_b_w;
  cal_t               cal_out_w;

  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign cfg_ready = 1'b1;
  assign bias_s    = 19'(cfg_zone_offset_hours) * 19'sd3600 + 19'sd86400;
  assign unix      = in_ntp_seconds - NTP_UNIX_OFFSET;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b1;
      v0_r     <= 1'b0;
      bias_a_r <= BIAS_RESET;
      bias_b_r <= BIAS_RESET + SECS_PER_HOUR;
    end else begin
      busy_r <= 1'b0;
      v0_r   <= accept;
      if (cfg_valid && cfg_ready) begin
        bias_a_r <= bias_s[17:0];
        bias_b_r <= bias_s[17:0] + SECS_PER_HOUR;
      end
    end
    ua_r <= {1'b0, unix} + 33'(bias_a_r);
    ub_r <= {1'b0, unix} + 33'(bias_b_r);
  end

  ntpcal_split u_split_std (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v0_r),
    .in_secs   (ua_r),
    .out_valid (v_a_w),
    .out_cal   (cal_a_w)
  );

  ntpcal_split u_split_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v0_r),
    .in_secs   (ub_r),
    .out_valid (v_b_w),
    .out_cal   (cal_b_w)
  );

  ntpcal_dst u_dst (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (v_a_w),
    .in_std     (cal_a_w),
    .in_sum     (cal_b_w),
    .out_strobe (out_strobe),
    .out_cal    (cal_out_w),
    .out_summer (out_summer_time)
  );

  assign out_year_since_1900 = cal_out_w.year;
  assign out_month           = cal_out_w.month;
  assign out_day_of_month    = cal_out_w.mday;
  assign out_weekday         = cal_out_w.wday;
  assign out_hour            = cal_out_w.hour;
  assign out_minute          = cal_out_w.minute;
  assign out_second          = cal_out_w.second;

  `NTPCAL_ASSERT_IMPL(a_lane_align, clk, rst_n, 1'b1, v_a_w == v_b_w, "split lanes out of step")
  `NTPCAL_ASSERT_IMPL(a_bias_gap, clk, rst_n, 1'b1, bias_b_r == bias_a_r + SECS_PER_HOUR, "bias pair mismatch")
  `NTPCAL_ASSERT_NEXT(a_lane_to_out, clk, rst_n, v_a_w, out_strobe, "lane result not delivered")

endmodule

`default_nettype wire
